// ===== src/npc_pkg.sv =====
package npc_pkg;

  localparam int unsigned COORD_WIDTH = 32;
  localparam int unsigned FRAC_BITS   = 16;

  // coordinate difference, ratio, product, remainder and sum widths; divide steps
  localparam int unsigned DIFF_W    = COORD_WIDTH + 1;
  localparam int unsigned RATIO_W   = FRAC_BITS + 1;
  localparam int unsigned PROD_W    = DIFF_W + RATIO_W;
  localparam int unsigned REM_W     = DIFF_W + 1;
  localparam int unsigned SUM_W     = PROD_W - FRAC_BITS;
  localparam int unsigned DIV_STEPS = FRAC_BITS + 1;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

  localparam logic MODE_MOVE = 1'b0;
  localparam logic MODE_DRAW = 1'b1;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef struct packed {
    logic   mode;
    coord_t x;
    coord_t y;
    coord_t z;
  } vtx_t;

  // what one input vertex does to the pending vertex
  typedef struct packed {
    logic push;   // first step emits pending and replaces it, else edits coords
    logic xing;   // first step takes the interpolated point
    logic mode;   // mode of a pushed vertex in the first step
    logic two;    // a second step pushes the input vertex
    logic mode2;  // mode of that second push
  } act_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CROSS,
    ST_ACT1,
    ST_ACT2,
    ST_FLUSH
  } npc_state_e;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_DIV,
    PH_MULX,
    PH_MULY,
    PH_ADDY,
    PH_FIN
  } npc_phase_e;

  function automatic logic [DIFF_W-1:0] abs_diff(logic signed [DIFF_W-1:0] v);
    logic signed [DIFF_W-1:0] n;
    n = -v;
    return v[DIFF_W-1] ? DIFF_W'(n) : DIFF_W'(v);
  endfunction

endpackage

// ===== src/npc_if.sv =====
interface npc_in_if;
  import npc_pkg::*;
  logic   valid;
  logic   ready;
  logic   in_mode;
  coord_t in_x;
  coord_t in_y;
  coord_t in_z;
  logic   in_last;

  modport source (output valid, output in_mode, output in_x, output in_y, output in_z,
                  output in_last, input ready);
  modport sink (input valid, input in_mode, input in_x, input in_y, input in_z,
                input in_last, output ready);
endinterface

interface npc_out_if;
  import npc_pkg::*;
  logic   valid;
  logic   ready;
  logic   out_mode;
  coord_t out_x;
  coord_t out_y;
  coord_t out_z;
  logic   out_last;

  modport source (output valid, output out_mode, output out_x, output out_y, output out_z,
                  output out_last, input ready);
  modport sink (input valid, input out_mode, input out_x, input out_y, input out_z,
                input out_last, output ready);
endinterface

// ===== src/near_plane_polyline_clipper.sv =====
// Channel  Port   Dir  Fields                                   Transfer
// -------  -----  ---  ---------------------------------------  -----------------
// vertex   in_i   in   in_mode, in_x, in_y, in_z, in_last       valid && ready
// clipped  out_o  out  out_mode, out_x, out_y, out_z, out_last  valid && ready
//
// A vertex whose segment crosses z=0 first waits for npc_interp, which runs 17
// restoring divide steps for the ratio and then the two multiplies.
// Reset: rst_ni is asynchronous, active low; it empties the previous and pending
// vertex and the output register. Stalls: in_i.ready is high only between items;
// an emission waits while the output register holds a result not yet taken.
module near_plane_polyline_clipper (
  input logic         clk_i,
  input logic         rst_ni,
  npc_in_if.sink      in_i,
  npc_out_if.source   out_o
);
  import npc_pkg::*;

  npc_state_e state_q, state_d;

  vtx_t v_q;            // input vertex under work
  logic last_q;
  act_t act_q;
  vtx_t pend_q, pend_d; // pending output vertex
  logic pend_valid_q, pend_valid_d;
  vtx_t prev_q, prev_d; // previous input vertex
  logic prev_valid_q, prev_valid_d;
  vtx_t out_q, out_d;   // output register
  logic out_last_q, out_last_d;
  logic out_valid_q, out_valid_d;

  logic   accept;
  vtx_t   in_v;
  act_t   act_new;
  logic   behind;
  logic   cross_done;
  coord_t cross_x, cross_y;
  logic   cur_push, cur_cross, cur_mode, final_act;
  vtx_t   src;
  logic   out_free, step_ok;

  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign in_v       = '{mode: in_i.in_mode, x: in_i.in_x, y: in_i.in_y, z: in_i.in_z};
  assign behind     = in_i.in_z[COORD_WIDTH-1];

  // Decide at transfer time what this vertex does to the pending vertex.
  always_comb begin
    act_new = '0;
    if (behind) begin
      if (in_i.in_mode == MODE_DRAW) begin
        if (prev_valid_q && !prev_q.z[COORD_WIDTH-1]) begin
          // leaving the visible side: draw to the crossing, then move to the vertex
          act_new.push  = 1'b1;
          act_new.xing  = 1'b1;
          act_new.mode  = MODE_DRAW;
          act_new.two   = 1'b1;
          act_new.mode2 = MODE_MOVE;
        end else if (!pend_valid_q) begin
          act_new.push = 1'b1;
          act_new.mode = MODE_MOVE;
        end
      end else if (!(pend_valid_q && pend_q.mode == MODE_MOVE)) begin
        act_new.push = 1'b1;
        act_new.mode = in_i.in_mode;
      end
    end else if (pend_valid_q && pend_q.z[COORD_WIDTH-1]) begin
      if (in_i.in_mode == MODE_DRAW) begin
        // entering the visible side: pending moves to the crossing
        act_new.xing  = 1'b1;
        act_new.two   = 1'b1;
        act_new.mode2 = MODE_DRAW;
      end
    end else begin
      act_new.push = 1'b1;
      act_new.mode = in_i.in_mode;
    end
  end

  npc_interp u_interp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept && act_new.xing),
    .ax_i    (prev_q.x),
    .ay_i    (prev_q.y),
    .az_i    (prev_q.z),
    .bx_i    (in_i.in_x),
    .by_i    (in_i.in_y),
    .bz_i    (in_i.in_z),
    .done_o  (cross_done),
    .x_o     (cross_x),
    .y_o     (cross_y)
  );

  // current pending-vertex step
  always_comb begin
    if (state_q == ST_ACT2) begin
      cur_push  = 1'b1;
      cur_cross = 1'b0;
      cur_mode  = act_q.mode2;
      final_act = 1'b1;
    end else begin
      cur_push  = act_q.push;
      cur_cross = act_q.xing;
      cur_mode  = act_q.mode;
      final_act = !act_q.two;
    end
  end

  assign src.mode = cur_mode;
  assign src.x    = cur_cross ? cross_x : v_q.x;
  assign src.y    = cur_cross ? cross_y : v_q.y;
  assign src.z    = cur_cross ? '0 : v_q.z;

  assign out_free = !out_valid_q || out_o.ready;

  always_comb begin
    case (state_q)
      ST_ACT1, ST_ACT2: step_ok = !cur_push || !pend_valid_q || out_free;
      ST_FLUSH:         step_ok = !pend_valid_q || out_free;
      default:          step_ok = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (accept) state_d = act_new.xing ? ST_CROSS : ST_ACT1;
      ST_CROSS: if (cross_done) state_d = ST_ACT1;
      ST_ACT1, ST_ACT2: begin
        if (step_ok) begin
          if (!final_act)  state_d = ST_ACT2;
          else if (last_q) state_d = ST_FLUSH;
          else             state_d = ST_IDLE;
        end
      end
      ST_FLUSH: if (step_ok) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // vertex updates and emissions
  always_comb begin
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q;
    prev_d       = prev_q;
    prev_valid_d = prev_valid_q;
    out_d        = out_q;
    out_last_d   = out_last_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    case (state_q)
      ST_ACT1, ST_ACT2: begin
        if (step_ok) begin
          if (cur_push) begin
            if (pend_valid_q) begin
              out_d       = pend_q;
              out_last_d  = 1'b0;
              out_valid_d = 1'b1;
            end
            pend_d       = src;
            pend_valid_d = 1'b1;
          end else begin
            // coordinate edit keeps the pending mode
            pend_d      = src;
            pend_d.mode = pend_q.mode;
          end
          if (final_act) begin
            prev_d       = v_q;
            prev_valid_d = 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        if (step_ok) begin
          if (pend_valid_q) begin
            out_d       = pend_q;
            out_last_d  = 1'b1;
            out_valid_d = 1'b1;
          end
          pend_valid_d = 1'b0;
          prev_valid_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      pend_valid_q <= 1'b0;
      prev_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      pend_valid_q <= pend_valid_d;
      prev_valid_q <= prev_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q     <= pend_d;
    prev_q     <= prev_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
    if (accept) begin
      v_q    <= in_v;
      last_q <= in_i.in_last;
      act_q  <= act_new;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.out_mode = out_q.mode;
  assign out_o.out_x    = out_q.x;
  assign out_o.out_y    = out_q.y;
  assign out_o.out_z    = out_q.z;
  assign out_o.out_last = out_last_q;

endmodule

// ===== src/npc_interp.sv =====
module npc_interp (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  npc_pkg::coord_t ax_i,
  input  npc_pkg::coord_t ay_i,
  input  npc_pkg::coord_t az_i,
  input  npc_pkg::coord_t bx_i,
  input  npc_pkg::coord_t by_i,
  input  npc_pkg::coord_t bz_i,
  output logic            done_o,
  output npc_pkg::coord_t x_o,
  output npc_pkg::coord_t y_o
);
  import npc_pkg::*;

  npc_phase_e ph_q, ph_d;
  logic [CNT_W-1:0]   cnt_q;
  logic [REM_W-1:0]   rem_q;
  logic [DIFF_W-1:0]  den_q;
  logic [RATIO_W-1:0] quo_q;
  logic [DIFF_W-1:0]  mx_q, my_q;
  logic               sx_q, sy_q;
  coord_t             ax_q, ay_q;
  logic [PROD_W-1:0]  prod_q;
  coord_t             x_q, y_q;

  logic signed [DIFF_W-1:0] dz, dx, dy;
  logic [REM_W-1:0]   trial, den_ext;
  logic               ge;
  logic [RATIO_W-1:0] ratio;
  logic [SUM_W-1:0]   mag;

  assign dz = DIFF_W'(az_i) - DIFF_W'(bz_i);
  assign dx = DIFF_W'(bx_i) - DIFF_W'(ax_i);
  assign dy = DIFF_W'(by_i) - DIFF_W'(ay_i);

  // restoring step: the first one compares without shifting
  assign trial   = (cnt_q == '0) ? rem_q : {rem_q[REM_W-2:0], 1'b0};
  assign den_ext = REM_W'(den_q);
  assign ge      = trial >= den_ext;
  // zero divisor yields a zero ratio
  assign ratio   = (den_q == '0) ? '0 : quo_q;
  assign mag     = prod_q[PROD_W-1:FRAC_BITS];

  function automatic coord_t add_delta(coord_t a, logic neg, logic [SUM_W-1:0] m);
    logic signed [SUM_W-1:0] base, delta, sum;
    base  = SUM_W'(a);
    delta = neg ? -$signed(m) : $signed(m);
    sum   = base + delta;
    return sum[COORD_WIDTH-1:0];
  endfunction

  always_comb begin
    ph_d = ph_q;
    case (ph_q)
      PH_IDLE: if (start_i) ph_d = PH_DIV;
      PH_DIV:  if (cnt_q == CNT_W'(DIV_STEPS - 1)) ph_d = PH_MULX;
      PH_MULX: ph_d = PH_MULY;
      PH_MULY: ph_d = PH_ADDY;
      PH_ADDY: ph_d = PH_FIN;
      PH_FIN:  ph_d = PH_IDLE;
      default: ph_d = PH_IDLE;
    endcase
  end

  assign done_o = (ph_q == PH_FIN);
  assign x_o    = x_q;
  assign y_o    = y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q  <= PH_IDLE;
      cnt_q <= '0;
    end else begin
      ph_q <= ph_d;
      if (ph_q == PH_DIV) cnt_q <= cnt_q + CNT_W'(1);
      else                cnt_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (ph_q)
      PH_IDLE: begin
        if (start_i) begin
          rem_q <= REM_W'(abs_diff(DIFF_W'(az_i)));
          den_q <= abs_diff(dz);
          quo_q <= '0;
          ax_q  <= ax_i;
          ay_q  <= ay_i;
          mx_q  <= abs_diff(dx);
          my_q  <= abs_diff(dy);
          sx_q  <= dx[DIFF_W-1];
          sy_q  <= dy[DIFF_W-1];
        end
      end
      PH_DIV: begin
        rem_q <= ge ? trial - den_ext : trial;
        quo_q <= {quo_q[RATIO_W-2:0], ge};
      end
      PH_MULX: prod_q <= PROD_W'(mx_q) * PROD_W'(ratio);
      PH_MULY: begin
        x_q    <= add_delta(ax_q, sx_q, mag);
        prod_q <= PROD_W'(my_q) * PROD_W'(ratio);
      end
      PH_ADDY: y_q <= add_delta(ay_q, sy_q, mag);
      default: ;
    endcase
  end

endmodule

// ===== tb/tb_near_plane_polyline_clipper.sv =====
module tb_near_plane_polyline_clipper;
  timeunit 1ns;
  timeprecision 1ps;

  import npc_pkg::*;

  // Stimulus size and run limits
  localparam int unsigned ITEMS      = 330;
  localparam int unsigned CYC_LIMIT  = 400_000;
  localparam int unsigned HOLD_CYC   = 400;   // long output hold-off
  localparam int unsigned TAIL_CYC   = 60;    // > one crossing plus flush
  localparam coord_t      Q_ONE      = 32'sh0001_0000;

  // One vertex as offered on the input channel; wait_idle makes the sender
  // pause until every predicted output vertex has been taken.
  typedef struct {
    logic   mode;
    coord_t x;
    coord_t y;
    coord_t z;
    logic   last;
    bit     wait_idle;
  } vtx_item_t;

  // One clipped vertex as seen on the output channel
  typedef struct packed {
    logic   mode;
    coord_t x;
    coord_t y;
    coord_t z;
    logic   last;
  } clip_vtx_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  npc_in_if  vtx_ch ();
  npc_out_if clip_ch ();

  near_plane_polyline_clipper dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (vtx_ch),
    .out_o  (clip_ch)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ------------------------------------------------------------------
  // Clipper predictor: own copy of the previous input vertex and the
  // pending output vertex, plus the queue of vertices still to come out.
  // ------------------------------------------------------------------
  logic      prev_ok;
  vtx_t      prev_v;
  logic      pend_ok;
  vtx_t      pend_v;
  clip_vtx_t clip_exp [$];

  vtx_item_t vtx_q [$];   // vertices waiting for the driver

  int unsigned err_cnt     = 0;
  int unsigned vtx_seen    = 0;
  int unsigned clip_seen   = 0;
  int unsigned cross_cnt   = 0;
  int unsigned end_cnt     = 0;
  int unsigned cyc_cnt     = 0;
  logic        in_fire     = 1'b0;
  logic        out_hold    = 1'b0;

  task automatic log_mismatch(input string msg);
    err_cnt++;
    $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  // ratio = |za| / |za - zb| as an unsigned fraction, restoring division,
  // truncated; a zero divisor gives zero
  function automatic longint unsigned depth_ratio(coord_t za, coord_t zb);
    longint unsigned num, den, rem, q;
    longint          dz;
    int              i;
    num = (za < 0) ? -longint'(za) : longint'(za);
    dz  = longint'(za) - longint'(zb);
    den = (dz < 0) ? -dz : dz;
    if (den == 0) return 0;
    q   = 0;
    rem = num;
    if (rem >= den) begin
      q   = 1;
      rem = rem - den;
    end
    for (i = 0; i < FRAC_BITS; i++) begin
      rem = rem << 1;
      q   = q << 1;
      if (rem >= den) begin
        q   = q | 1;
        rem = rem - den;
      end
    end
    return q;
  endfunction

  // a + ((b - a) * ratio >> FRAC_BITS), product truncated toward zero
  function automatic coord_t lerp_coord(coord_t a, coord_t b, longint unsigned ratio);
    longint          d;
    longint unsigned mag, prod;
    d    = longint'(b) - longint'(a);
    mag  = (d < 0) ? -d : d;
    prod = (mag * ratio) >> FRAC_BITS;
    return coord_t'((d < 0) ? longint'(a) - longint'(prod) : longint'(a) + longint'(prod));
  endfunction

  // point where segment a->b meets the z = 0 plane
  function automatic vtx_t near_cross(vtx_t a, vtx_t b);
    vtx_t            p;
    longint unsigned r;
    r      = depth_ratio(a.z, b.z);
    p.mode = MODE_DRAW;
    p.x    = lerp_coord(a.x, b.x, r);
    p.y    = lerp_coord(a.y, b.y, r);
    p.z    = '0;
    cross_cnt++;
    return p;
  endfunction

  // append one predicted output vertex
  function automatic void queue_exp(vtx_t v, logic lst);
    clip_vtx_t c;
    c = '{v.mode, v.x, v.y, v.z, lst};
    clip_exp.insert(clip_exp.size(), c);
  endfunction

  // a new output vertex sends the old pending one out first
  function automatic void push_pending(vtx_t v);
    if (pend_ok) queue_exp(pend_v, 1'b0);
    pend_v  = v;
    pend_ok = 1'b1;
  endfunction

  // overwrite in place: coordinates only, the mode stays
  function automatic void edit_pending(vtx_t v);
    pend_v.x = v.x;
    pend_v.y = v.y;
    pend_v.z = v.z;
  endfunction

  function automatic void clip_predict(vtx_item_t it);
    vtx_t v, t;
    v = '{it.mode, it.x, it.y, it.z};
    if ($signed(v.z) < 0) begin
      // vertex behind the camera
      if (v.mode == MODE_DRAW) begin
        if (prev_ok && $signed(prev_v.z) >= 0) begin
          // leaving the visible side: draw to the crossing, then park a move
          push_pending(near_cross(prev_v, v));
          t      = v;
          t.mode = MODE_MOVE;
          push_pending(t);
        end else if (pend_ok) begin
          edit_pending(v);
        end else begin
          t      = v;
          t.mode = MODE_MOVE;
          push_pending(t);
        end
      end else begin
        if (pend_ok && pend_v.mode == MODE_MOVE) edit_pending(v);
        else push_pending(v);
      end
    end else begin
      // vertex in front
      if (pend_ok && $signed(pend_v.z) < 0) begin
        if (v.mode == MODE_MOVE) begin
          edit_pending(v);
        end else begin
          // coming back into view: the parked move lands on the crossing
          edit_pending(near_cross(prev_v, v));
          push_pending(v);
        end
      end else begin
        push_pending(v);
      end
    end
    prev_v  = v;
    prev_ok = 1'b1;
    if (it.last) begin
      if (pend_ok) queue_exp(pend_v, 1'b1);
      pend_ok = 1'b0;
      prev_ok = 1'b0;
      end_cnt++;
    end
  endfunction

  // ------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------
  task automatic add_vtx(input logic mode, input coord_t x, input coord_t y, input coord_t z,
                         input logic last, input bit wait_idle = 1'b0);
    vtx_item_t it;
    it = '{mode, x, y, z, last, wait_idle};
    vtx_q.insert(vtx_q.size(), it);
  endtask

  function automatic coord_t corner_val();
    case ($urandom_range(0, 5))
      0:       return 32'sh0000_0000;
      1:       return -32'sd1;
      2:       return 32'sd1;
      3:       return 32'sh7fff_ffff;
      4:       return 32'sh8000_0000;
      default: return Q_ONE;
    endcase
  endfunction

  // depth: mostly close to the plane so that segments cross it often
  function automatic coord_t rand_depth();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 15) return corner_val();
    if (pick < 55) return coord_t'(int'($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000);
    if (pick < 75) return coord_t'(int'($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
    return coord_t'($urandom);
  endfunction

  function automatic coord_t rand_plane();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 15) return corner_val();
    if (pick < 30) return coord_t'(int'($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000);
    return coord_t'($urandom);
  endfunction

  // ------------------------------------------------------------------
  // Input driver: bursts of transfers separated by random gaps; inputs
  // change on the falling edge only.
  // ------------------------------------------------------------------
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(negedge clk_i) begin : vtx_driver
    logic      offer;
    vtx_item_t nx;
    if (rst_ni && (!vtx_ch.valid || in_fire)) begin
      offer = 1'b0;
      if (gap_left > 0 && !out_hold) begin
        gap_left--;
      end else if (vtx_q.size() > 0 && !(vtx_q[0].wait_idle && clip_exp.size() != 0)) begin
        nx    = vtx_q.pop_front();
        offer = 1'b1;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          // a third of the bursts follow back to back
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
      vtx_ch.valid <= offer;
      if (offer) begin
        vtx_ch.in_mode <= nx.mode;
        vtx_ch.in_x    <= nx.x;
        vtx_ch.in_y    <= nx.y;
        vtx_ch.in_z    <= nx.z;
        vtx_ch.in_last <= nx.last;
      end
    end
  end

  // ------------------------------------------------------------------
  // Output ready: rotating stall pattern, reloaded every so often, with
  // all-ready stretches; out_hold forces a long stall.
  // ------------------------------------------------------------------
  logic [7:0]  stall_pat  = 8'hff;
  int unsigned stall_left = 0;

  always @(negedge clk_i) begin : clip_ready_gen
    if (rst_ni) begin
      if (stall_left == 0) begin
        stall_left = $urandom_range(20, 120);
        stall_pat  = ($urandom_range(0, 3) == 0) ? 8'hff : 8'($urandom);
        if (stall_pat == 8'h00) stall_pat = 8'h01;
      end
      stall_left--;
      stall_pat = {stall_pat[6:0], stall_pat[7]};
      clip_ch.ready <= stall_pat[0] && !out_hold;
    end
  end

  // Long output hold-off once traffic is flowing; the sender keeps offering
  // so the clipper backs up and drops its input ready.
  initial begin : long_stall
    wait (vtx_seen >= 60);
    @(posedge clk_i);
    out_hold = 1'b1;
    repeat (HOLD_CYC) @(posedge clk_i);
    out_hold = 1'b0;
  end

  // ------------------------------------------------------------------
  // Monitor: input transfers feed the predictor, output transfers are
  // checked against the oldest predicted vertex.
  // ------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    vtx_item_t it;
    clip_vtx_t got, want;
    in_fire = 1'b0;
    if (rst_ni) begin
      if (vtx_ch.valid && vtx_ch.ready) begin
        it = '{vtx_ch.in_mode, vtx_ch.in_x, vtx_ch.in_y, vtx_ch.in_z, vtx_ch.in_last, 1'b0};
        clip_predict(it);
        in_fire = 1'b1;
        vtx_seen++;
      end
      if (clip_ch.valid && clip_ch.ready) begin
        got = '{clip_ch.out_mode, clip_ch.out_x, clip_ch.out_y, clip_ch.out_z,
                clip_ch.out_last};
        clip_seen++;
        if (clip_exp.size() == 0) begin
          log_mismatch($sformatf("unexpected output vertex mode=%0b x=%0d y=%0d z=%0d last=%0b",
                                 got.mode, $signed(got.x), $signed(got.y), $signed(got.z),
                                 got.last));
        end else begin
          want = clip_exp.pop_front();
          if (got.mode !== want.mode)
            log_mismatch($sformatf("out %0d mode %0b, want %0b", clip_seen, got.mode, want.mode));
          if (got.x !== want.x)
            log_mismatch($sformatf("out %0d x %0d, want %0d", clip_seen,
                                   $signed(got.x), $signed(want.x)));
          if (got.y !== want.y)
            log_mismatch($sformatf("out %0d y %0d, want %0d", clip_seen,
                                   $signed(got.y), $signed(want.y)));
          if (got.z !== want.z)
            log_mismatch($sformatf("out %0d z %0d, want %0d", clip_seen,
                                   $signed(got.z), $signed(want.z)));
          if (got.last !== want.last)
            log_mismatch($sformatf("out %0d last %0b, want %0b", clip_seen, got.last, want.last));
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin : watchdog
    cyc_cnt++;
    if (cyc_cnt >= CYC_LIMIT) begin
      $display("Timeout after %0d cycles, %0d vertices still queued for output",
               cyc_cnt, clip_exp.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ------------------------------------------------------------------
  // Stimulus, reset and end of run
  // ------------------------------------------------------------------
  initial begin : main
    int unsigned kind, len, k;
    logic        mode, lst;

    rst_ni          = 1'b0;
    vtx_ch.valid    = 1'b0;
    vtx_ch.in_mode  = MODE_MOVE;
    vtx_ch.in_x     = '0;
    vtx_ch.in_y     = '0;
    vtx_ch.in_z     = '0;
    vtx_ch.in_last  = 1'b0;
    clip_ch.ready   = 1'b0;
    prev_ok         = 1'b0;
    pend_ok         = 1'b0;
    prev_v          = '0;
    pend_v          = '0;

    // Directed: first vertex a draw in front, then out of view and back
    add_vtx(MODE_DRAW, Q_ONE, 2 * Q_ONE, 5 * Q_ONE, 1'b0);
    add_vtx(MODE_DRAW, 3 * Q_ONE, -Q_ONE, -2 * Q_ONE, 1'b0);   // crosses going back
    add_vtx(MODE_DRAW, 4 * Q_ONE, Q_ONE, -3 * Q_ONE, 1'b0);    // parked move edited
    add_vtx(MODE_DRAW, -Q_ONE, 7 * Q_ONE, Q_ONE, 1'b0);        // crosses coming forward
    add_vtx(MODE_MOVE, 5, 6, -Q_ONE, 1'b0);                    // new move behind
    add_vtx(MODE_MOVE, 8, 9, -7, 1'b0);                        // move edits a move
    add_vtx(MODE_MOVE, 10, 11, 0, 1'b0);                       // z = 0 counts as in front
    add_vtx(MODE_DRAW, 12, 13, Q_ONE, 1'b1);                   // last flushes pending
    // Single vertex polyline at the coordinate extremes, after a full drain
    add_vtx(MODE_MOVE, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 1'b1, 1'b1);
    // First vertex a draw behind, then full-range crossing forward
    add_vtx(MODE_DRAW, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 1'b0);
    add_vtx(MODE_DRAW, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 1'b0);
    add_vtx(MODE_MOVE, -1, -1, -1, 1'b1);
    // Full-range crossing backward, then forward to exactly z = 0
    add_vtx(MODE_MOVE, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 1'b0);
    add_vtx(MODE_DRAW, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 1'b0);
    add_vtx(MODE_DRAW, 0, 0, 0, 1'b1);
    // Smallest crossing: ratio of exactly one
    add_vtx(MODE_MOVE, 100, -100, -1, 1'b0);
    add_vtx(MODE_DRAW, -100, 100, 0, 1'b1);
    // Lone draw in front that is also the last vertex
    add_vtx(MODE_DRAW, -5, 5, Q_ONE, 1'b1);
    // Zig-zag around the plane
    add_vtx(MODE_MOVE, Q_ONE, Q_ONE, 0, 1'b0);
    add_vtx(MODE_DRAW, -Q_ONE, Q_ONE, -1, 1'b0);
    add_vtx(MODE_DRAW, Q_ONE, -Q_ONE, 0, 1'b0);
    add_vtx(MODE_MOVE, 3, 3, 1, 1'b0);
    add_vtx(MODE_DRAW, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000, 1'b1);

    // Random polylines: mostly well formed, some with random modes and
    // missing or stray end flags
    while (vtx_q.size() < ITEMS) begin
      kind = $urandom_range(0, 99);
      len  = $urandom_range(1, 8);
      for (k = 0; k < len; k++) begin
        if (kind < 85) begin
          if (k == 0) mode = ($urandom_range(0, 9) == 0) ? MODE_DRAW : MODE_MOVE;
          else mode = ($urandom_range(0, 11) == 0) ? MODE_MOVE : MODE_DRAW;
          lst = (k == len - 1);
        end else begin
          mode = ($urandom_range(0, 1) == 0) ? MODE_MOVE : MODE_DRAW;
          lst  = ($urandom_range(0, 3) == 0);
        end
        add_vtx(mode, rand_plane(), rand_plane(), rand_depth(), lst,
                (k == 0) && ($urandom_range(0, 39) == 0));
      end
    end
    // the run must end on a flushed polyline
    vtx_q[vtx_q.size() - 1].last = 1'b1;

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    // every vertex handed over, then every predicted output taken
    while (vtx_q.size() != 0 || vtx_ch.valid) @(posedge clk_i);
    while (clip_exp.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYC) @(posedge clk_i);

    $display("Run covered %0d input vertices in %0d polylines, %0d clipped vertices out,",
             vtx_seen, end_cnt, clip_seen);
    $display("%0d near-plane crossings, a %0d-cycle output stall and drain pauses; %0d errors",
             cross_cnt, HOLD_CYC, err_cnt);
    if (err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
